@@ src/ospag_pkg.sv @@
`default_nettype none

package ospag_pkg;

  // Field and register widths.
  localparam int ADDR_W    = 40;
  localparam int ROW_W     = 21;
  localparam int PACK_W    = 4;
  localparam int NCH_W     = 3;
  localparam int CB_W      = 9;
  localparam int LEAF_W    = 16;
  localparam int V_W       = LEAF_W + 1;
  localparam int PLEN_W    = 5;
  localparam int BB_W      = CB_W + 2;
  localparam int BIS_W     = 8;
  localparam int GRP_W     = 3;
  localparam int CMP_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_A_W   = 16;
  localparam int MUL_B_W   = 21;
  localparam int MAX_PACK  = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_LEVELS = 16;
  localparam int DEF_MAX_CHUNKS = 4;

  // Register values after reset.
  localparam logic [ROW_W-1:0]  ROW_BYTES_RST   = ROW_W'(8192);
  localparam logic [PACK_W-1:0] PACK_LEVELS_RST = PACK_W'(1);
  localparam logic [NCH_W-1:0]  CHUNKS_RST      = NCH_W'(1);
  localparam logic [CB_W-1:0]   CHUNK_BYTES_RST = CB_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TREE_BASE    = 3'd0,
    REG_TREE_LIMIT   = 3'd1,
    REG_ROW_BYTES    = 3'd2,
    REG_PACK_LEVELS  = 3'd3,
    REG_CHUNKS       = 3'd4,
    REG_CHUNK_BYTES  = 3'd5,
    REG_LAST_SUBTREE = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEVEL,
    S_GROUP_MUL,
    S_GROUP_ADD,
    S_SUB_MUL,
    S_SUB_ADD,
    S_BKT_MUL,
    S_BKT_ADD,
    S_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    MAC_GROUP,
    MAC_SUB,
    MAC_BKT
  } mac_sel_t;

  typedef struct packed {
    logic boundary;
    logic first_level;
    logic chunk_last;
    logic level_last;
  } seq_status_t;

  typedef struct packed {
    logic     in_ready;
    logic     out_valid;
    logic     load_item;
    logic     bis_step;
    logic     mac_en;
    mac_sel_t mac_sel;
    logic     grp_wr;
    logic     sub_wr;
    logic     addr_load;
    logic     chunk_step;
    logic     level_step;
  } seq_ctrl_t;

endpackage

`default_nettype wire

@@ src/ospag_mac.sv @@
`default_nettype none

// Shared multiply-add unit: the product is registered, the add follows in the next cycle.
module ospag_mac import ospag_pkg::*; (
  input  wire logic               clk,
  input  wire logic               mul_en,
  input  wire logic [MUL_A_W-1:0] mul_a,
  input  wire logic [MUL_B_W-1:0] mul_b,
  input  wire logic [ADDR_W-1:0]  addend,
  output logic      [ADDR_W-1:0]  sum
);

  logic [MUL_A_W+MUL_B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  assign sum = addend + ADDR_W'(prod_r);

endmodule

`default_nettype wire

@@ src/ospag_seq.sv @@
`default_nettype none

// Sequencer: walks one path level at a time and steps the shared unit.
module ospag_seq import ospag_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        out_ready,
  input  wire seq_status_t status,
  output seq_ctrl_t        ctrl
);

  seq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctrl      = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_item = 1'b1;
          state_nxt      = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (status.boundary) begin
          state_nxt = status.first_level ? S_SUB_MUL : S_GROUP_MUL;
        end else begin
          ctrl.bis_step = 1'b1;
          state_nxt     = S_BKT_MUL;
        end
      end
      S_GROUP_MUL: begin
        ctrl.mac_en  = 1'b1;
        ctrl.mac_sel = MAC_GROUP;
        state_nxt    = S_GROUP_ADD;
      end
      S_GROUP_ADD: begin
        ctrl.mac_sel = MAC_GROUP;
        ctrl.grp_wr  = 1'b1;
        state_nxt    = S_SUB_MUL;
      end
      S_SUB_MUL: begin
        ctrl.mac_en  = 1'b1;
        ctrl.mac_sel = MAC_SUB;
        state_nxt    = S_SUB_ADD;
      end
      S_SUB_ADD: begin
        ctrl.mac_sel = MAC_SUB;
        ctrl.sub_wr  = 1'b1;
        state_nxt    = S_BKT_MUL;
      end
      S_BKT_MUL: begin
        ctrl.mac_en  = 1'b1;
        ctrl.mac_sel = MAC_BKT;
        state_nxt    = S_BKT_ADD;
      end
      S_BKT_ADD: begin
        ctrl.mac_sel   = MAC_BKT;
        ctrl.addr_load = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        ctrl.out_valid = 1'b1;
        if (out_ready) begin
          if (!status.chunk_last) begin
            ctrl.chunk_step = 1'b1;
          end else if (!status.level_last) begin
            ctrl.level_step = 1'b1;
            state_nxt       = S_LEVEL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/oram_path_subtree_address_gen.sv @@
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_leaf_bucket[15:0], in_is_write
// out_      output     out_valid / out_ready   out_chunk_address[39:0], out_write_request,
//                                              out_last_chunk, out_out_of_range
// cfg_      input      cfg_valid / cfg_ready   cfg_index[2:0], cfg_data[39:0]
//
// One input beat is taken only while the block is idle; it then produces P * C output beats,
// P being the path length and C the clamped chunk count. Each level passes the bucket offset
// through the one shared multiply-add unit, in a product step and a sum step; a level that
// opens a new group of levels first does the same for the group base (not at the root) and
// the subtree start. Output stalls hold the current beat and nothing upstream is taken meanwhile.
// Reset is synchronous, active low, and loads the register defaults; cfg_ready is always high.
module oram_path_subtree_address_gen import ospag_pkg::*; #(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [LEAF_W-1:0]    in_leaf_bucket,
  input  wire logic                 in_is_write,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [ADDR_W-1:0]    out_chunk_address,
  output logic                      out_write_request,
  output logic                      out_last_chunk,
  output logic                      out_out_of_range,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  // Level counter and path length must hold MAX_LEVELS itself.
  localparam int LVL_W = $clog2(MAX_LEVELS + 1);
  // Chunk counter and chunk count must hold MAX_CHUNKS itself.
  localparam int CNT_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS + 1) : 1;

  // Configuration registers.
  logic [ADDR_W-1:0] tree_base_r, tree_limit_r;
  logic [ROW_W-1:0]  row_bytes_r, last_bytes_r;
  logic [PACK_W-1:0] pack_levels_r;
  logic [NCH_W-1:0]  chunks_r;
  logic [CB_W-1:0]   chunk_bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_base_r   <= '0;
      tree_limit_r  <= '0;
      row_bytes_r   <= ROW_BYTES_RST;
      pack_levels_r <= PACK_LEVELS_RST;
      chunks_r      <= CHUNKS_RST;
      chunk_bytes_r <= CHUNK_BYTES_RST;
      last_bytes_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TREE_BASE:    tree_base_r   <= cfg_data;
        REG_TREE_LIMIT:   tree_limit_r  <= cfg_data;
        REG_ROW_BYTES:    row_bytes_r   <= cfg_data[ROW_W-1:0];
        REG_PACK_LEVELS:  pack_levels_r <= cfg_data[PACK_W-1:0];
        REG_CHUNKS:       chunks_r      <= cfg_data[NCH_W-1:0];
        REG_CHUNK_BYTES:  chunk_bytes_r <= cfg_data[CB_W-1:0];
        REG_LAST_SUBTREE: last_bytes_r  <= cfg_data[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  seq_ctrl_t   ctrl;
  seq_status_t status;

  ospag_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  assign in_ready  = ctrl.in_ready;
  assign out_valid = ctrl.out_valid;

  // Item decode at acceptance: path length, truncation of over-long paths, and the
  // clamped pack and chunk counts.
  logic [V_W-1:0]    v_in, v_load;
  logic [PLEN_W-1:0] plen_full;
  logic [LVL_W-1:0]  plen_load;
  logic [PACK_W-1:0] k_load;
  logic [NCH_W-1:0]  nch_load;
  logic [BB_W-1:0]   bb_load;

  always_comb begin
    v_in      = V_W'(in_leaf_bucket) + V_W'(1);
    plen_full = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v_in[i]) begin
        plen_full = PLEN_W'(i + 1);
      end
    end
    if (CMP_W'(plen_full) > CMP_W'(MAX_LEVELS)) begin
      v_load    = v_in >> (plen_full - PLEN_W'(MAX_LEVELS));
      plen_load = LVL_W'(MAX_LEVELS);
    end else begin
      v_load    = v_in;
      plen_load = LVL_W'(plen_full);
    end

    if (pack_levels_r == '0) begin
      k_load = PACK_W'(1);
    end else if (pack_levels_r > PACK_W'(MAX_PACK)) begin
      k_load = PACK_W'(MAX_PACK);
    end else begin
      k_load = pack_levels_r;
    end

    if (chunks_r == '0) begin
      nch_load = NCH_W'(1);
    end else if (chunks_r > NCH_W'(MAX_CHUNKS)) begin
      nch_load = NCH_W'(MAX_CHUNKS);
    end else begin
      nch_load = chunks_r;
    end

    case (nch_load)
      NCH_W'(2): bb_load = BB_W'(chunk_bytes_r) << 1;
      NCH_W'(3): bb_load = BB_W'(chunk_bytes_r) + (BB_W'(chunk_bytes_r) << 1);
      NCH_W'(4): bb_load = BB_W'(chunk_bytes_r) << 2;
      default:   bb_load = BB_W'(chunk_bytes_r);
    endcase
  end

  // Per-item working registers.
  logic [V_W-1:0]    v_r;
  logic [LVL_W-1:0]  plen_r, level_r;
  logic [PACK_W-1:0] k_r;
  logic [CNT_W-1:0]  nch_r, chunk_r;
  logic [BB_W-1:0]   bb_r;
  logic              wr_r;
  logic [GRP_W-1:0]  grp_cnt_r;
  logic [BIS_W-1:0]  bis_r;
  logic [ADDR_W-1:0] group_base_r, subtree_start_r, addr_r;

  // The prefix is the heap id plus one of the bucket on the current level.
  logic [V_W-1:0]     prefix;
  logic [V_W-1:0]     offset;
  logic [CMP_W-1:0]   group_shift;
  logic               bottom_group;
  logic [ROW_W-1:0]   sub_size;

  always_comb begin
    prefix       = v_r >> (plen_r - LVL_W'(1) - level_r);
    offset       = prefix ^ (V_W'(1) << level_r);
    group_shift  = CMP_W'(level_r) - CMP_W'(k_r);
    bottom_group = (CMP_W'(level_r) + CMP_W'(k_r)) > CMP_W'(plen_r);
    sub_size     = (bottom_group && last_bytes_r != '0) ? last_bytes_r : row_bytes_r;
  end

  assign status.boundary    = (grp_cnt_r == '0);
  assign status.first_level = (level_r == '0);
  assign status.chunk_last  = ((CNT_W + 1)'(chunk_r) + (CNT_W + 1)'(1))
                              == (CNT_W + 1)'(nch_r);
  assign status.level_last  = ((LVL_W + 1)'(level_r) + (LVL_W + 1)'(1))
                              == (LVL_W + 1)'(plen_r);

  // Operand selection for the shared unit: the group step adds the size of the
  // previous group, the subtree step places the subtree inside its group, and the
  // bucket step places the bucket inside its subtree.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [ADDR_W-1:0]  addend, mac_sum;

  always_comb begin
    case (ctrl.mac_sel)
      MAC_GROUP: begin
        mul_a  = MUL_A_W'(1) << group_shift;
        mul_b  = row_bytes_r;
        addend = group_base_r;
      end
      MAC_SUB: begin
        mul_a  = offset[MUL_A_W-1:0];
        mul_b  = sub_size;
        addend = group_base_r;
      end
      default: begin
        mul_a  = MUL_A_W'(bis_r);
        mul_b  = MUL_B_W'(bb_r);
        addend = subtree_start_r;
      end
    endcase
  end

  ospag_mac u_mac (
    .clk    (clk),
    .mul_en (ctrl.mac_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .addend (addend),
    .sum    (mac_sum)
  );

  // Control counters are cleared by reset; the address registers carry payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= '0;
      grp_cnt_r <= '0;
      chunk_r   <= '0;
    end else begin
      if (ctrl.load_item) begin
        level_r   <= '0;
        grp_cnt_r <= '0;
      end else if (ctrl.level_step) begin
        level_r   <= level_r + LVL_W'(1);
        grp_cnt_r <= (grp_cnt_r == GRP_W'(k_r - PACK_W'(1))) ? '0 : grp_cnt_r + GRP_W'(1);
      end
      if (ctrl.addr_load) begin
        chunk_r <= '0;
      end else if (ctrl.chunk_step) begin
        chunk_r <= chunk_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      v_r          <= v_load;
      plen_r       <= plen_load;
      k_r          <= k_load;
      nch_r        <= CNT_W'(nch_load);
      bb_r         <= bb_load;
      wr_r         <= in_is_write;
      group_base_r <= tree_base_r;
    end else if (ctrl.grp_wr) begin
      group_base_r <= mac_sum;
    end
    if (ctrl.sub_wr) begin
      subtree_start_r <= mac_sum;
      bis_r           <= '0;
    end else if (ctrl.bis_step) begin
      bis_r <= {bis_r[BIS_W-2:0], 1'b0} + BIS_W'(1) + BIS_W'(prefix[0]);
    end
    if (ctrl.addr_load) begin
      addr_r <= mac_sum;
    end else if (ctrl.chunk_step) begin
      addr_r <= addr_r + ADDR_W'(chunk_bytes_r);
    end
  end

  assign out_chunk_address = addr_r;
  assign out_write_request = wr_r;
  assign out_last_chunk    = status.chunk_last && status.level_last;
  assign out_out_of_range  = (addr_r >= tree_limit_r);

endmodule

`default_nettype wire

@@ src/ospag_checker.sv @@
`default_nettype none

module ospag_checker import ospag_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] out_chunk_address,
  input wire logic              out_last_chunk
);

  // The block never takes an item while a result beat is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while an output beat is pending");

  // No address is offered in the cycle after an item is accepted.
  a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("output beat in the cycle after acceptance");

  // The final beat of a path returns the block to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_chunk) |=> in_ready)
    else $error("block not idle after the last beat of a path");

  // A beat that is not the last keeps the block busy.
  a_busy_mid_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_chunk) |=> !in_ready)
    else $error("block went idle in the middle of a path");

  // A stalled beat holds its address.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_chunk_address)))
    else $error("stalled output beat changed");

endmodule

bind oram_path_subtree_address_gen ospag_checker u_ospag_checker (.*);

`default_nettype wire
